/* rtl/core/msr_pkg.sv */
// Shared types and constants for the motor speed ramp block.
`timescale 1ns / 1ps

package msr_pkg;

   // Item opcodes
   typedef enum logic [1:0] {
      OP_TICK      = 2'd0,
      OP_SET_SPEED = 2'd1,
      OP_SET_DIR   = 2'd2,
      OP_ESTOP     = 2'd3
   } opcode_type;

   // Step used while slowing down for a direction change
   localparam logic [7:0] TURN_STEP = 8'd10;

   // Register file
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic REG_DUTY_FLOOR   = 1'b0;
   localparam logic REG_DUTY_CEILING = 1'b1;
   localparam logic [7:0] DUTY_FLOOR_RESET   = 8'd0;
   localparam logic [7:0] DUTY_CEILING_RESET = 8'd255;

   // One request beat
   typedef struct packed {
      opcode_type  opcode;
      logic [7:0]  target_speed;
      logic [7:0]  ramp_step;
      logic        new_direction;
   } req_beat_type;

   // Ramp state as seen by the duty pipeline
   typedef struct packed {
      logic [7:0]  speed;
      logic        direction;
      logic        ramping;
      logic        pending;
   } ramp_status_type;

   // Duty scaling configuration
   typedef struct packed {
      logic [7:0]  duty_floor;
      logic [7:0]  duty_ceiling;
   } duty_cfg_type;

   // One response beat
   typedef struct packed {
      logic [7:0]  pwm_duty;
      logic        drive_left;
      logic        drive_right;
      logic [7:0]  speed_setting;
      logic        ramping;
   } rsp_beat_type;

endpackage

/* rtl/core/msr_if.sv */
// Valid/ready channel interfaces for request and response beats.
`timescale 1ns / 1ps

interface msr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [7:0]  target_speed;
   logic [7:0]  ramp_step;
   logic        new_direction;

   modport source (output valid, output opcode, output target_speed,
                   output ramp_step, output new_direction, input ready);
   modport sink   (input valid, input opcode, input target_speed,
                   input ramp_step, input new_direction, output ready);
endinterface

interface msr_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  pwm_duty;
   logic        drive_left;
   logic        drive_right;
   logic [7:0]  speed_setting;
   logic        ramping;

   modport source (output valid, output pwm_duty, output drive_left,
                   output drive_right, output speed_setting, output ramping,
                   input ready);
   modport sink   (input valid, input pwm_duty, input drive_left,
                   input drive_right, input speed_setting, input ramping,
                   output ready);
endinterface

/* rtl/core/msr_csr.sv */
// APB register file holding the duty floor and ceiling.
`timescale 1ns / 1ps

module msr_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [msr_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  logic [msr_pkg::CSR_DATA_WIDTH-1:0]   pwdata,
   output logic [msr_pkg::CSR_DATA_WIDTH-1:0]   prdata,
   output logic                                 pready,
   output msr_pkg::duty_cfg_type                cfg
);
   import msr_pkg::*;

   logic [7:0] duty_floor_ff,   duty_floor_in;
   logic [7:0] duty_ceiling_ff, duty_ceiling_in;
   logic       wr_en;
   logic       reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[2];

   // Write decode
   always_comb begin
      duty_floor_in   = duty_floor_ff;
      duty_ceiling_in = duty_ceiling_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_DUTY_FLOOR:   duty_floor_in   = pwdata[7:0];
            REG_DUTY_CEILING: duty_ceiling_in = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_floor_ff   <= DUTY_FLOOR_RESET;
         duty_ceiling_ff <= DUTY_CEILING_RESET;
      end else begin
         duty_floor_ff   <= duty_floor_in;
         duty_ceiling_ff <= duty_ceiling_in;
      end
   end

   // Read mux
   always_comb begin
      prdata = '0;
      unique case (reg_sel)
         REG_DUTY_FLOOR:   prdata = {{(CSR_DATA_WIDTH-8){1'b0}}, duty_floor_ff};
         REG_DUTY_CEILING: prdata = {{(CSR_DATA_WIDTH-8){1'b0}}, duty_ceiling_ff};
         default: ;
      endcase
   end

   assign cfg.duty_floor   = duty_floor_ff;
   assign cfg.duty_ceiling = duty_ceiling_ff;

endmodule

/* rtl/core/msr_ramp.sv */
// Ramp state: speed, target, step and direction, updated once per accepted beat.
`timescale 1ns / 1ps

module msr_ramp (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  msr_pkg::req_beat_type    beat,
   output msr_pkg::ramp_status_type status
);
   import msr_pkg::*;

   logic [7:0] speed_ff,   speed_in;
   logic [7:0] target_ff,  target_in;
   logic [7:0] step_ff,    step_in;
   logic       dir_ff,     dir_in;
   logic       pend_ff,    pend_in;
   logic       pend_dir_ff, pend_dir_in;

   logic [7:0] diff;
   logic       rising;
   logic [7:0] tick_speed;

   // One ramp step toward the target, landing on it when less than a step remains
   always_comb begin
      rising     = speed_ff < target_ff;
      diff       = rising ? (target_ff - speed_ff) : (speed_ff - target_ff);
      tick_speed = speed_ff;
      if (step_ff != 8'd0 && speed_ff != target_ff) begin
         if (diff < step_ff) begin
            tick_speed = target_ff;
         end else if (rising) begin
            tick_speed = speed_ff + step_ff;
         end else begin
            tick_speed = speed_ff - step_ff;
         end
      end
   end

   // Next state per opcode
   always_comb begin
      speed_in    = speed_ff;
      target_in   = target_ff;
      step_in     = step_ff;
      dir_in      = dir_ff;
      pend_in     = pend_ff;
      pend_dir_in = pend_dir_ff;
      if (accept) begin
         unique case (beat.opcode)
            OP_TICK: begin
               speed_in = tick_speed;
               if (pend_ff && tick_speed == 8'd0) begin
                  dir_in  = pend_dir_ff;
                  pend_in = 1'b0;
               end
            end
            OP_SET_SPEED: begin
               pend_in   = 1'b0;
               step_in   = beat.ramp_step;
               target_in = (beat.ramp_step == 8'd0) ? speed_ff : beat.target_speed;
            end
            OP_SET_DIR: begin
               pend_dir_in = beat.new_direction;
               target_in   = 8'd0;
               step_in     = TURN_STEP;
               // at rest the new direction takes effect at once
               if (speed_ff == 8'd0) begin
                  dir_in  = beat.new_direction;
                  pend_in = 1'b0;
               end else begin
                  pend_in = 1'b1;
               end
            end
            OP_ESTOP: begin
               speed_in  = 8'd0;
               target_in = 8'd0;
               if (pend_ff) begin
                  dir_in  = pend_dir_ff;
                  pend_in = 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff    <= '0;
         target_ff   <= '0;
         step_ff     <= '0;
         dir_ff      <= 1'b0;
         pend_ff     <= 1'b0;
         pend_dir_ff <= 1'b0;
      end else begin
         speed_ff    <= speed_in;
         target_ff   <= target_in;
         step_ff     <= step_in;
         dir_ff      <= dir_in;
         pend_ff     <= pend_in;
         pend_dir_ff <= pend_dir_in;
      end
   end

   assign status.speed     = speed_ff;
   assign status.direction = dir_ff;
   assign status.ramping   = (speed_ff != target_ff) || pend_ff;
   assign status.pending   = pend_ff;

endmodule

/* rtl/core/msr_duty.sv */
// Two-stage duty scaler: span multiply, then divide by 255, offset and clamp.
`timescale 1ns / 1ps

module msr_duty (
   input  logic                     clock,
   input  logic                     mul_load,
   input  logic                     out_load,
   input  msr_pkg::ramp_status_type status,
   input  msr_pkg::duty_cfg_type    cfg,
   output msr_pkg::rsp_beat_type    rsp_beat
);
   import msr_pkg::*;

   // multiply stage
   logic signed [8:0]  span;
   logic signed [17:0] prod_in;
   logic signed [17:0] prod_ff;
   logic [7:0]         floor_ff;
   ramp_status_type    status_ff;

   // scale stage
   logic               neg;
   logic [17:0]        abs_prod;
   logic [16:0]        mag;
   logic [16:0]        quot_sum;
   logic [8:0]         quot;
   logic signed [9:0]  duty_raw;
   rsp_beat_type       rsp_in;
   rsp_beat_type       rsp_ff;

   assign span    = $signed({1'b0, cfg.duty_ceiling}) - $signed({1'b0, cfg.duty_floor});
   assign prod_in = span * $signed({1'b0, status.speed});

   always_ff @(posedge clock) begin
      if (mul_load) begin
         prod_ff   <= prod_in;
         floor_ff  <= cfg.duty_floor;
         status_ff <= status;
      end
   end

   // floor division by 255; negative products round toward minus infinity
   always_comb begin
      neg      = prod_ff[17];
      abs_prod = neg ? 18'(-prod_ff) : 18'(prod_ff);
      mag      = neg ? (abs_prod[16:0] + 17'd254) : abs_prod[16:0];
      // x/255 == (x + (x >> 8) + 1) >> 8 over the magnitude range used here
      quot_sum = mag + (mag >> 8) + 17'd1;
      quot     = quot_sum[16:8];
      duty_raw = $signed({2'b00, floor_ff})
               + (neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot}));
   end

   // clamp and pack the response
   always_comb begin
      if (status_ff.speed == 8'd0 || duty_raw < 10'sd0) begin
         rsp_in.pwm_duty = 8'd0;
      end else if (duty_raw > 10'sd255) begin
         rsp_in.pwm_duty = 8'd255;
      end else begin
         rsp_in.pwm_duty = duty_raw[7:0];
      end
      rsp_in.drive_left    = status_ff.direction;
      rsp_in.drive_right   = ~status_ff.direction;
      rsp_in.speed_setting = status_ff.speed;
      rsp_in.ramping       = status_ff.ramping;
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_beat = rsp_ff;

endmodule

/* rtl/core/motor_speed_ramp_hbridge.sv */
// Top level of the H-bridge speed ramp: handshake control, register file, ramp and duty.
//
//   channel   direction  protocol     beat
//   req_chan  in         valid/ready  opcode, target_speed, ramp_step, new_direction
//   rsp_chan  out        valid/ready  pwm_duty, drive_left, drive_right, speed_setting, ramping
//   psel..    in/out     APB          duty_floor at 0x0, duty_ceiling at 0x4
//
// One request beat per cycle while the response is taken; the ramp state updates at
// the accepting edge, and the response then passes through the registers in order
// (ramp state, span multiply, divide-and-clamp output register).
// Reset is synchronous and active high; it clears the ramp state and valid bits
// and loads the duty floor with 0 and the ceiling with 255.
// A stalled response holds the pipeline; req_chan.ready drops only when all
// three stages hold beats and the response is not taken.
`timescale 1ns / 1ps

module motor_speed_ramp_hbridge (
   input  logic                                 clock,
   input  logic                                 reset,
   msr_req_if.sink                              req_chan,
   msr_rsp_if.source                            rsp_chan,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [msr_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  logic [msr_pkg::CSR_DATA_WIDTH-1:0]   pwdata,
   output logic [msr_pkg::CSR_DATA_WIDTH-1:0]   prdata,
   output logic                                 pready
);
   import msr_pkg::*;

   logic            state_valid_ff, state_valid_in;
   logic            mul_valid_ff,   mul_valid_in;
   logic            rsp_valid_ff,   rsp_valid_in;
   logic            out_load;
   logic            mul_load;
   logic            accept;
   req_beat_type    req_beat;
   ramp_status_type status;
   duty_cfg_type    cfg;
   rsp_beat_type    rsp_beat;

   // Pipeline flow control
   assign out_load       = !rsp_valid_ff || rsp_chan.ready;
   assign mul_load       = !mul_valid_ff || out_load;
   assign req_chan.ready = !state_valid_ff || mul_load;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      state_valid_in = accept ? 1'b1 : (mul_load ? 1'b0 : state_valid_ff);
      mul_valid_in   = mul_load ? state_valid_ff : mul_valid_ff;
      rsp_valid_in   = out_load ? mul_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_valid_ff <= 1'b0;
         mul_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_valid_ff <= state_valid_in;
         mul_valid_ff   <= mul_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Request beat
   assign req_beat.opcode        = opcode_type'(req_chan.opcode);
   assign req_beat.target_speed  = req_chan.target_speed;
   assign req_beat.ramp_step     = req_chan.ramp_step;
   assign req_beat.new_direction = req_chan.new_direction;

   msr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   msr_ramp u_ramp (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .beat   (req_beat),
      .status (status)
   );

   msr_duty u_duty (
      .clock    (clock),
      .mul_load (mul_load),
      .out_load (out_load),
      .status   (status),
      .cfg      (cfg),
      .rsp_beat (rsp_beat)
   );

   // Response beat
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.pwm_duty      = rsp_beat.pwm_duty;
   assign rsp_chan.drive_left    = rsp_beat.drive_left;
   assign rsp_chan.drive_right   = rsp_beat.drive_right;
   assign rsp_chan.speed_setting = rsp_beat.speed_setting;
   assign rsp_chan.ramping       = rsp_beat.ramping;

   // A direction change never stays pending once the motor is at rest
   a_no_pending_at_rest: assert property (@(posedge clock) disable iff (reset)
      !(status.pending && status.speed == 8'd0))
      else $error("direction change left pending at zero speed");

   // Ramp state waiting for the multiply stage must not move
   a_state_held: assert property (@(posedge clock) disable iff (reset)
      state_valid_ff && !mul_load |=> $stable(status))
      else $error("ramp state changed while its beat was stalled");

   // Zero speed always drives zero duty
   a_zero_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_beat.speed_setting == 8'd0 |-> rsp_beat.pwm_duty == 8'd0)
      else $error("nonzero duty at zero speed");

   // Bridge lines are always complementary
   a_bridge_lines: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_beat.drive_left != rsp_beat.drive_right)
      else $error("bridge lines not complementary");

endmodule
